>>> design/prg_pkg.sv
// ----------------------------------------------------------------------------
// Palette ramp generator package
// Shared constants, payload types, controller commands and status, and the
// fixed-point to level conversion.
// ----------------------------------------------------------------------------
package prg_pkg;

  // Palette geometry and number formats.
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned CH_W    = 6;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned RGB_W   = NUM_CH * CH_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIVD_W  = CH_W + FRAC_W;
  localparam int unsigned STEP_W  = DIVD_W + 1;
  localparam int unsigned ACC_W   = DIVD_W + 2;
  localparam int unsigned COLS_W  = 9;
  localparam int unsigned DCNT_W  = $clog2(DIVD_W + 1);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(16);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_LINEAR = 2'd2,
    OP_RECT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_SHORT  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Which pair of entries a ramp segment works on.
  typedef enum logic [1:0] {
    PAIR_LIN   = 2'd0,
    PAIR_LEFT  = 2'd1,
    PAIR_RIGHT = 2'd2,
    PAIR_ROW   = 2'd3
  } pair_e;

  typedef enum logic [1:0] {
    RS_IDX = 2'd0,
    RS_A   = 2'd1,
    RS_B   = 2'd2
  } rsel_e;

  typedef enum logic [1:0] {
    WS_OP    = 2'd0,
    WS_RUN   = 2'd1,
    WS_LEFT  = 2'd2,
    WS_RIGHT = 2'd3
  } wsel_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] first_index;
    logic [ADDR_W-1:0] second_index;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] read_red;
    logic [CH_W-1:0] read_green;
    logic [CH_W-1:0] read_blue;
    logic [1:0]      status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start_idx_div;
    logic    start_fix_div;
    logic    ld_xy;
    logic    chk;
    logic    ld_pair;
    pair_e   ld_src;
    logic    take_step;
    pair_e   dst;
    logic    mem_re;
    rsel_e   rsel;
    logic    cap_a;
    logic    mem_we;
    wsel_e   wsel;
    logic    run_step;
    logic    row_adv;
    logic    res_set;
    logic    res_rd;
    status_e res_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic div_done;
    logic short_span;
    logic rect_bad;
    logic narrow;
    logic run_last;
    logic rows_done;
  } sts_t;

  // Integer part of a running fixed-point level, clamped to the level range.
  function automatic logic [CH_W-1:0] to_level(input logic signed [ACC_W-1:0] acc);
    logic [CH_W-1:0] lvl;
    if (acc[ACC_W-1]) begin
      lvl = '0;
    end else if (|acc[ACC_W-2:DIVD_W]) begin
      lvl = '1;
    end else begin
      lvl = acc[DIVD_W-1:FRAC_W];
    end
    return lvl;
  endfunction

endpackage

>>> design/prg_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one palette operation per transaction.
// ----------------------------------------------------------------------------
interface prg_in_if;
  logic               valid;
  logic               ready;
  prg_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/prg_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one operation result per transaction.
// ----------------------------------------------------------------------------
interface prg_out_if;
  logic               valid;
  logic               ready;
  prg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/prg_div.sv
// ----------------------------------------------------------------------------
// Restoring divider lane
// Unsigned divider producing one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
module prg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [prg_pkg::DIVD_W-1:0]    dividend_i,
  input  logic [prg_pkg::COLS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [prg_pkg::DIVD_W-1:0]    quot_o,
  output logic [prg_pkg::COLS_W-1:0]    rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [prg_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  logic [prg_pkg::DIVD_W-1:0]    quot_q, quot_d;
  logic [prg_pkg::COLS_W-1:0]    rem_q, rem_d;
  logic [prg_pkg::COLS_W-1:0]    dvsr_q, dvsr_d;
  logic [prg_pkg::COLS_W:0]      trial;
  logic [prg_pkg::COLS_W:0]      diff;
  logic                          fits;

  // One shift-and-subtract step.
  always_comb begin
    trial  = {rem_q, quot_q[prg_pkg::DIVD_W-1]};
    diff   = trial - {1'b0, dvsr_q};
    fits   = (trial >= {1'b0, dvsr_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[prg_pkg::DIVD_W-2:0], fits};
      rem_d  = fits ? diff[prg_pkg::COLS_W-1:0] : trial[prg_pkg::COLS_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == prg_pkg::DCNT_W'(prg_pkg::DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> design/prg_dp.sv
// ----------------------------------------------------------------------------
// Palette ramp datapath
// Palette memory, three divider lanes, ramp accumulators and grid geometry.
// ----------------------------------------------------------------------------
module prg_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  prg_pkg::in_item_t             in_item_i,
  input  logic                          cfg_we_i,
  input  logic [prg_pkg::COLS_W-1:0]    cfg_data_i,
  input  prg_pkg::cmd_t                 cmd_i,
  output prg_pkg::sts_t                 sts_o,
  output prg_pkg::out_item_t            res_o
);

  localparam int unsigned AW  = prg_pkg::ADDR_W;
  localparam int unsigned CW  = prg_pkg::CH_W;
  localparam int unsigned NC  = prg_pkg::NUM_CH;
  localparam int unsigned PW  = prg_pkg::ADDR_W + prg_pkg::COLS_W + 1;

  // Configuration and request registers.
  logic [prg_pkg::COLS_W-1:0] cols_q;
  logic [prg_pkg::COLS_W-1:0] cols_eff;
  logic [1:0]                 op_q;
  logic [AW-1:0]              idx1_q, lo_q, hi_q;
  logic [prg_pkg::RGB_W-1:0]  rgb_q;

  // Grid geometry.
  logic [AW-1:0] x1_q, x2_q, y1_q, y2_q;
  logic          bad_q;
  logic [AW-1:0] tl_q, bl_q, width_q, rows_q, row_l_q, rows_left_q;
  logic [PW-1:0] prod1, prod2, sum_tl, sum_bl, sum_br;
  logic [AW-1:0] xa, xb;
  logic [prg_pkg::COLS_W-1:0] row_nx;

  // Segment registers.
  logic [AW-1:0] addr_a_q, addr_b_q, span_q, cur_q;
  logic [CW-1:0] lvl_a_q [NC];
  logic          neg_q   [NC];
  logic signed [prg_pkg::STEP_W-1:0] step_q [NC], stepl_q [NC], stepr_q [NC];
  logic signed [prg_pkg::STEP_W-1:0] step_new [NC];
  logic signed [prg_pkg::ACC_W-1:0]  acc_q [NC], accl_q [NC], accr_q [NC];
  logic signed [prg_pkg::ACC_W-1:0]  acc_n [NC], acc_init [NC];

  // Memory.
  logic [prg_pkg::RGB_W-1:0] mem_q [prg_pkg::ENTRIES];
  logic [prg_pkg::ENTRIES-1:0] vld_q;
  logic [prg_pkg::RGB_W-1:0] rdata_q;
  logic [CW-1:0]             rd_ch [NC];
  logic [AW-1:0]             raddr, waddr;
  logic [prg_pkg::RGB_W-1:0] wdata, run_word, left_word, right_word;

  // Divider lanes.
  logic [prg_pkg::DIVD_W-1:0] dvd [NC];
  logic [prg_pkg::COLS_W-1:0] dvs [NC];
  logic [prg_pkg::DIVD_W-1:0] quot_w [NC];
  logic [prg_pkg::COLS_W-1:0] rem_w [NC];
  logic                       done_w [NC];
  logic [CW-1:0]              mag [NC];
  logic                       neg_new [NC];

  prg_pkg::out_item_t res_q;

  assign cols_eff = (cols_q == '0) ? prg_pkg::COLS_W'(1) : cols_q;

  // Channel views of the read word and the words to be written.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      rd_ch[c] = rdata_q[(NC-1-c)*CW +: CW];
      acc_n[c] = acc_q[c] + $signed({step_q[c][prg_pkg::STEP_W-1], step_q[c]});
      acc_init[c] = $signed({2'b00, lvl_a_q[c], {prg_pkg::FRAC_W{1'b0}}});
      run_word[(NC-1-c)*CW +: CW]   = prg_pkg::to_level(acc_n[c]);
      left_word[(NC-1-c)*CW +: CW]  = prg_pkg::to_level(accl_q[c]);
      right_word[(NC-1-c)*CW +: CW] = prg_pkg::to_level(accr_q[c]);
    end
  end

  // Divider operands: grid position of the corners or a level difference.
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      neg_new[c] = (rd_ch[c] < lvl_a_q[c]);
      mag[c]     = neg_new[c] ? (lvl_a_q[c] - rd_ch[c]) : (rd_ch[c] - lvl_a_q[c]);
      if (cmd_i.start_idx_div) begin
        dvs[c] = cols_eff;
        if (c == 0) begin
          dvd[c] = prg_pkg::DIVD_W'(lo_q);
        end else if (c == 1) begin
          dvd[c] = prg_pkg::DIVD_W'(hi_q);
        end else begin
          dvd[c] = '0;
        end
      end else begin
        dvs[c] = prg_pkg::COLS_W'(span_q);
        dvd[c] = {mag[c], {prg_pkg::FRAC_W{1'b0}}};
      end
      if (span_q == '0) begin
        step_new[c] = '0;
      end else if (neg_q[c]) begin
        step_new[c] = -$signed({1'b0, quot_w[c]});
      end else begin
        step_new[c] = $signed({1'b0, quot_w[c]});
      end
    end
  end

  for (genvar g = 0; g < NC; g++) begin : g_lane
    prg_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.start_idx_div | cmd_i.start_fix_div),
      .dividend_i (dvd[g]),
      .divisor_i  (dvs[g]),
      .done_o     (done_w[g]),
      .quot_o     (quot_w[g]),
      .rem_o      (rem_w[g])
    );
  end

  // Rectangle geometry: one multiply and add per product.
  assign prod1  = PW'(y1_q) * PW'(cols_eff);
  assign prod2  = PW'(y2_q) * PW'(cols_eff);
  assign sum_tl = prod1 + PW'(x1_q);
  assign sum_bl = prod2 + PW'(x1_q);
  assign sum_br = prod2 + PW'(x2_q);
  assign xa     = rem_w[0][AW-1:0];
  assign xb     = rem_w[1][AW-1:0];
  assign row_nx = prg_pkg::COLS_W'(row_l_q) + cols_eff;

  // Memory port selection.
  always_comb begin
    unique case (cmd_i.rsel)
      prg_pkg::RS_A:   raddr = addr_a_q;
      prg_pkg::RS_B:   raddr = addr_b_q;
      default:         raddr = idx1_q;
    endcase
    unique case (cmd_i.wsel)
      prg_pkg::WS_RUN: begin
        waddr = cur_q;
        wdata = run_word;
      end
      prg_pkg::WS_LEFT: begin
        waddr = row_l_q;
        wdata = left_word;
      end
      prg_pkg::WS_RIGHT: begin
        waddr = row_l_q + width_q;
        wdata = right_word;
      end
      default: begin
        waddr = idx1_q;
        wdata = rgb_q;
      end
    endcase
  end

  // Palette memory; unwritten entries read as black.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= vld_q[raddr] ? mem_q[raddr] : '0;
    end
  end

  // Entry valid bits and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      cols_q <= prg_pkg::COLS_RESET;
    end else begin
      if (cmd_i.mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // Request capture, geometry, segment and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      op_q   <= in_item_i.operation;
      idx1_q <= in_item_i.first_index;
      rgb_q  <= {in_item_i.red, in_item_i.green, in_item_i.blue};
      if (in_item_i.first_index < in_item_i.second_index) begin
        lo_q <= in_item_i.first_index;
        hi_q <= in_item_i.second_index;
      end else begin
        lo_q <= in_item_i.second_index;
        hi_q <= in_item_i.first_index;
      end
    end
    if (cmd_i.ld_xy) begin
      x1_q <= (xa < xb) ? xa : xb;
      x2_q <= (xa < xb) ? xb : xa;
      y1_q <= quot_w[0][AW-1:0];
      y2_q <= quot_w[1][AW-1:0];
    end
    if (cmd_i.chk) begin
      bad_q       <= (sum_br >= PW'(prg_pkg::ENTRIES));
      tl_q        <= sum_tl[AW-1:0];
      bl_q        <= sum_bl[AW-1:0];
      width_q     <= x2_q - x1_q;
      rows_q      <= y2_q - y1_q;
      row_l_q     <= sum_tl[AW-1:0];
      rows_left_q <= y2_q - y1_q;
    end
    if (cmd_i.ld_pair) begin
      unique case (cmd_i.ld_src)
        prg_pkg::PAIR_LEFT: begin
          addr_a_q <= tl_q;
          addr_b_q <= bl_q;
          span_q   <= rows_q;
        end
        prg_pkg::PAIR_RIGHT: begin
          addr_a_q <= tl_q + width_q;
          addr_b_q <= bl_q + width_q;
          span_q   <= rows_q;
        end
        prg_pkg::PAIR_ROW: begin
          addr_a_q <= row_l_q;
          addr_b_q <= row_l_q + width_q;
          span_q   <= width_q;
        end
        default: begin
          addr_a_q <= lo_q;
          addr_b_q <= hi_q;
          span_q   <= hi_q - lo_q;
        end
      endcase
    end
    if (cmd_i.take_step && cmd_i.dst != prg_pkg::PAIR_LEFT &&
        cmd_i.dst != prg_pkg::PAIR_RIGHT) begin
      cur_q <= addr_a_q + 1'b1;
    end else if (cmd_i.run_step) begin
      cur_q <= cur_q + 1'b1;
    end
    if (cmd_i.row_adv) begin
      row_l_q     <= row_nx[AW-1:0];
      rows_left_q <= rows_left_q - 1'b1;
    end
    for (int c = 0; c < NC; c++) begin
      if (cmd_i.cap_a) begin
        lvl_a_q[c] <= rd_ch[c];
      end
      if (cmd_i.start_fix_div) begin
        neg_q[c] <= neg_new[c];
      end
      if (cmd_i.take_step) begin
        unique case (cmd_i.dst)
          prg_pkg::PAIR_LEFT: begin
            stepl_q[c] <= step_new[c];
            accl_q[c]  <= acc_init[c];
          end
          prg_pkg::PAIR_RIGHT: begin
            stepr_q[c] <= step_new[c];
            accr_q[c]  <= acc_init[c];
          end
          default: begin
            step_q[c] <= step_new[c];
            acc_q[c]  <= acc_init[c];
          end
        endcase
      end else if (cmd_i.run_step) begin
        acc_q[c] <= acc_n[c];
      end
      if (cmd_i.row_adv) begin
        accl_q[c] <= accl_q[c] + $signed({stepl_q[c][prg_pkg::STEP_W-1], stepl_q[c]});
        accr_q[c] <= accr_q[c] + $signed({stepr_q[c][prg_pkg::STEP_W-1], stepr_q[c]});
      end
    end
    if (cmd_i.res_set) begin
      res_q.read_red   <= cmd_i.res_rd ? rd_ch[0] : '0;
      res_q.read_green <= cmd_i.res_rd ? rd_ch[1] : '0;
      res_q.read_blue  <= cmd_i.res_rd ? rd_ch[2] : '0;
      res_q.status     <= cmd_i.res_code;
    end
  end

  // Status toward the controller.
  assign sts_o.op         = prg_pkg::op_e'(op_q);
  assign sts_o.div_done   = done_w[0];
  assign sts_o.short_span = ((hi_q - lo_q) < AW'(2));
  assign sts_o.rect_bad   = bad_q;
  assign sts_o.narrow     = (width_q < AW'(2));
  assign sts_o.run_last   = (cur_q == addr_b_q - 1'b1);
  assign sts_o.rows_done  = (rows_left_q == '0);

  assign res_o = res_q;

endmodule

>>> design/prg_ctrl.sv
// ----------------------------------------------------------------------------
// Palette ramp controller
// State machine that sequences reads, divisions and writes of each operation.
// ----------------------------------------------------------------------------
module prg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  prg_pkg::sts_t sts_i,
  output prg_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_IDIV  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_CHK2  = 4'd5;
  localparam logic [3:0] S_PRA   = 4'd6;
  localparam logic [3:0] S_PRB   = 4'd7;
  localparam logic [3:0] S_PCAP  = 4'd8;
  localparam logic [3:0] S_PDIV  = 4'd9;
  localparam logic [3:0] S_RUN   = 4'd10;
  localparam logic [3:0] S_ROWL  = 4'd11;
  localparam logic [3:0] S_ROWR  = 4'd12;
  localparam logic [3:0] S_ROWNX = 4'd13;
  localparam logic [3:0] S_RES   = 4'd14;

  logic [3:0]     state_q, state_d;
  prg_pkg::pair_e phase_q, phase_d;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.op)
          prg_pkg::OP_WRITE: begin
            cmd_o.mem_we   = 1'b1;
            cmd_o.wsel     = prg_pkg::WS_OP;
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = prg_pkg::ST_DONE;
            state_d        = S_RES;
          end
          prg_pkg::OP_READ: begin
            cmd_o.mem_re = 1'b1;
            cmd_o.rsel   = prg_pkg::RS_IDX;
            state_d      = S_RDW;
          end
          prg_pkg::OP_LINEAR: begin
            if (sts_i.short_span) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = prg_pkg::ST_SHORT;
              state_d        = S_RES;
            end else begin
              cmd_o.ld_pair = 1'b1;
              cmd_o.ld_src  = prg_pkg::PAIR_LIN;
              phase_d       = prg_pkg::PAIR_LIN;
              state_d       = S_PRA;
            end
          end
          default: begin
            cmd_o.start_idx_div = 1'b1;
            state_d             = S_IDIV;
          end
        endcase
      end
      S_RDW: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.res_rd   = 1'b1;
        cmd_o.res_code = prg_pkg::ST_DONE;
        state_d        = S_RES;
      end
      S_IDIV: begin
        if (sts_i.div_done) begin
          cmd_o.ld_xy = 1'b1;
          state_d     = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = S_CHK2;
      end
      S_CHK2: begin
        if (sts_i.rect_bad) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = prg_pkg::ST_REJECT;
          state_d        = S_RES;
        end else begin
          cmd_o.ld_pair = 1'b1;
          cmd_o.ld_src  = prg_pkg::PAIR_LEFT;
          phase_d       = prg_pkg::PAIR_LEFT;
          state_d       = S_PRA;
        end
      end
      // Read both ends of a segment and divide their difference.
      S_PRA: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rsel   = prg_pkg::RS_A;
        state_d      = S_PRB;
      end
      S_PRB: begin
        cmd_o.mem_re = 1'b1;
        cmd_o.rsel   = prg_pkg::RS_B;
        cmd_o.cap_a  = 1'b1;
        state_d      = S_PCAP;
      end
      S_PCAP: begin
        cmd_o.start_fix_div = 1'b1;
        state_d             = S_PDIV;
      end
      S_PDIV: begin
        if (sts_i.div_done) begin
          cmd_o.take_step = 1'b1;
          cmd_o.dst       = phase_q;
          unique case (phase_q)
            prg_pkg::PAIR_LEFT: begin
              cmd_o.ld_pair = 1'b1;
              cmd_o.ld_src  = prg_pkg::PAIR_RIGHT;
              phase_d       = prg_pkg::PAIR_RIGHT;
              state_d       = S_PRA;
            end
            prg_pkg::PAIR_RIGHT: begin
              state_d = S_ROWL;
            end
            default: begin
              state_d = S_RUN;
            end
          endcase
        end
      end
      // Write the interior entries of a segment, one per cycle.
      S_RUN: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wsel     = prg_pkg::WS_RUN;
        cmd_o.run_step = 1'b1;
        if (sts_i.run_last) begin
          if (phase_q == prg_pkg::PAIR_LIN) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = prg_pkg::ST_DONE;
            state_d        = S_RES;
          end else begin
            state_d = S_ROWNX;
          end
        end
      end
      S_ROWL: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = prg_pkg::WS_LEFT;
        state_d      = S_ROWR;
      end
      S_ROWR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = prg_pkg::WS_RIGHT;
        if (sts_i.narrow) begin
          state_d = S_ROWNX;
        end else begin
          cmd_o.ld_pair = 1'b1;
          cmd_o.ld_src  = prg_pkg::PAIR_ROW;
          phase_d       = prg_pkg::PAIR_ROW;
          state_d       = S_PRA;
        end
      end
      S_ROWNX: begin
        if (sts_i.rows_done) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = prg_pkg::ST_DONE;
          state_d        = S_RES;
        end else begin
          cmd_o.row_adv = 1'b1;
          state_d       = S_ROWL;
        end
      end
      S_RES: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= prg_pkg::PAIR_LIN;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

`ifndef SYNTHESIS
  // The palette is never written while waiting for a request.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cmd_o.mem_we)
    else $error("palette written while idle");

  // A division finishes only while the controller waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_IDIV || state_q == S_PDIV))
    else $error("division finished outside a wait state");

  // An accepted request is dispatched in the next cycle.
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted request not dispatched");
`endif

endmodule

>>> design/palette_ramp_generator.sv
// Each linear ramp segment runs the bit-serial divider; a rectangle divides
// for its left and right edges, rows and width being the corner differences,
// and, when not narrow, each row does its own segment division; one request
// at a time.
// Reset (async, active low) clears the controller, sets column count to 16
// and marks all palette entries black through per-entry valid bits at once.
// ----------------------------------------------------------------------------
// Palette ramp generator top level
// Palette memory with entry write, read, linear ramp and rectangular ramp.
// ----------------------------------------------------------------------------
module palette_ramp_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [prg_pkg::COLS_W-1:0] cfg_data_i,
  prg_in_if.sink                     in_i,
  prg_out_if.source                  res_o
);

  prg_pkg::cmd_t cmd;
  prg_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  prg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  prg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_i.valid & in_ready),
    .in_item_i   (in_i.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o.data)
  );

endmodule

>>> bench/palette_ramp_generator_test.sv
// ----------------------------------------------------------------------------
// Palette ramp generator testbench
// Drives write, read, linear and rectangular ramp requests with random gaps,
// predicts each result from a behavioral palette copy and checks every
// result transaction against it, under several column counts.
// ----------------------------------------------------------------------------
module palette_ramp_generator_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [prg_pkg::COLS_W-1:0] cfg_data_i = '0;

  prg_in_if  req_ch ();
  prg_out_if res_ch ();

  palette_ramp_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_ch.sink),
    .res_o      (res_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Predicted palette and grid width.
  logic [prg_pkg::CH_W-1:0] pal_model [prg_pkg::ENTRIES][prg_pkg::NUM_CH];
  int unsigned grid_cols;
  prg_pkg::out_item_t pending_results [$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  bit no_idle = 1'b0;

  function automatic logic [prg_pkg::CH_W-1:0] clamp_level(longint acc);
    longint v;
    if (acc < 0) return '0;
    v = acc / (longint'(1) << prg_pkg::FRAC_W);
    if (v > 63) v = 63;
    return v[prg_pkg::CH_W-1:0];
  endfunction

  function automatic longint slope(longint a, longint b, longint span);
    if (span <= 0) return 0;
    return ((b - a) * (longint'(1) << prg_pkg::FRAC_W)) / span;
  endfunction

  function automatic void fill_between(int lo, int hi);
    longint st, acc;
    for (int c = 0; c < prg_pkg::NUM_CH; c++) begin
      st = slope(pal_model[lo][c], pal_model[hi][c], hi - lo);
      acc = longint'(pal_model[lo][c]) << prg_pkg::FRAC_W;
      for (int i = lo + 1; i < hi; i++) begin
        acc += st;
        pal_model[i][c] = clamp_level(acc);
      end
    end
  endfunction

  function automatic prg_pkg::status_e rect_predict(int a, int b);
    int cols, lo, hi, x1, x2, y1, y2, l, r;
    longint accl[prg_pkg::NUM_CH], accr[prg_pkg::NUM_CH];
    longint stl[prg_pkg::NUM_CH], str[prg_pkg::NUM_CH];
    cols = (grid_cols == 0) ? 1 : grid_cols;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    x1 = lo % cols; x2 = hi % cols;
    if (x1 > x2) begin l = x1; x1 = x2; x2 = l; end
    y1 = lo / cols; y2 = hi / cols;
    if (y2 * cols + x2 >= prg_pkg::ENTRIES) return prg_pkg::ST_REJECT;
    for (int c = 0; c < prg_pkg::NUM_CH; c++) begin
      stl[c] = slope(pal_model[y1*cols+x1][c], pal_model[y2*cols+x1][c], y2 - y1);
      str[c] = slope(pal_model[y1*cols+x2][c], pal_model[y2*cols+x2][c], y2 - y1);
      accl[c] = longint'(pal_model[y1*cols+x1][c]) << prg_pkg::FRAC_W;
      accr[c] = longint'(pal_model[y1*cols+x2][c]) << prg_pkg::FRAC_W;
    end
    for (int y = y1; y <= y2; y++) begin
      l = y * cols + x1;
      r = y * cols + x2;
      for (int c = 0; c < prg_pkg::NUM_CH; c++) begin
        pal_model[l][c] = clamp_level(accl[c]);
        pal_model[r][c] = clamp_level(accr[c]);
      end
      if (x2 - x1 >= 2) fill_between(l, r);
      for (int c = 0; c < prg_pkg::NUM_CH; c++) begin
        accl[c] += stl[c];
        accr[c] += str[c];
      end
    end
    return prg_pkg::ST_DONE;
  endfunction

  // Apply one request to the palette copy and return its result.
  function automatic prg_pkg::out_item_t apply_request(prg_pkg::in_item_t req);
    prg_pkg::out_item_t res;
    int lo, hi;
    res = '0;
    case (prg_pkg::op_e'(req.operation))
      prg_pkg::OP_WRITE: begin
        pal_model[req.first_index][0] = req.red;
        pal_model[req.first_index][1] = req.green;
        pal_model[req.first_index][2] = req.blue;
      end
      prg_pkg::OP_READ: begin
        res.read_red   = pal_model[req.first_index][0];
        res.read_green = pal_model[req.first_index][1];
        res.read_blue  = pal_model[req.first_index][2];
      end
      prg_pkg::OP_LINEAR: begin
        lo = (req.first_index < req.second_index) ? req.first_index : req.second_index;
        hi = (req.first_index < req.second_index) ? req.second_index : req.first_index;
        if (hi - lo < 2) res.status = prg_pkg::ST_SHORT;
        else fill_between(lo, hi);
      end
      default: res.status = rect_predict(req.first_index, req.second_index);
    endcase
    return res;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 13);
  endfunction

  // Send one request transaction and record its expected result.
  // Valid stays high after acceptance until the next call or a drain, so
  // back-to-back requests drive valid only once per falling edge.
  task automatic send_request(prg_pkg::op_e op, int a, int b, int r, int g, int bl);
    prg_pkg::in_item_t req;
    req.operation = op;
    req.first_index = a[prg_pkg::ADDR_W-1:0];
    req.second_index = b[prg_pkg::ADDR_W-1:0];
    req.red = r[prg_pkg::CH_W-1:0];
    req.green = g[prg_pkg::CH_W-1:0];
    req.blue = bl[prg_pkg::CH_W-1:0];
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.data <= req;
    req_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_results.push_back(apply_request(req));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_write();
    send_request(prg_pkg::OP_WRITE, $urandom_range(255), $urandom_range(255),
                 $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endtask

  // Wait until all results are in, then let the block settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_columns(int unsigned cols);
    drain();
    cfg_data_i <= cols[prg_pkg::COLS_W-1:0];
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    grid_cols = cols;
  endtask

  // Result receiver: random stalls, compares against the oldest expectation.
  always @(negedge clk_i) res_ch.ready <= rst_ni && !idle_now();

  always @(posedge clk_i) begin
    prg_pkg::out_item_t exp_res;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", res_ch.data);
      end else begin
        exp_res = pending_results.pop_front();
        checked++;
        if (res_ch.data !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected rgb %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                     exp_res.read_red, exp_res.read_green, exp_res.read_blue,
                     exp_res.status, res_ch.data.read_red, res_ch.data.read_green,
                     res_ch.data.read_blue, res_ch.data.status);
        end
      end
    end
  end

  // Directed: extremes, every operation and short spans.
  task automatic test_directed();
    send_request(prg_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_request(prg_pkg::OP_READ, 255, 0, 0, 0, 0);
    send_request(prg_pkg::OP_WRITE, 0, 255, 63, 0, 63);
    send_request(prg_pkg::OP_WRITE, 255, 0, 0, 63, 0);
    send_request(prg_pkg::OP_READ, 0, 0, 0, 0, 0);
    send_request(prg_pkg::OP_LINEAR, 255, 0, 0, 0, 0);
    send_request(prg_pkg::OP_READ, 128, 0, 0, 0, 0);
    send_request(prg_pkg::OP_LINEAR, 10, 11, 0, 0, 0);
    send_request(prg_pkg::OP_LINEAR, 12, 12, 0, 0, 0);
    send_request(prg_pkg::OP_WRITE, 16, 0, 1, 62, 33);
    send_request(prg_pkg::OP_RECT, 0, 255, 0, 0, 0);
    send_request(prg_pkg::OP_READ, 17, 0, 0, 0, 0);
    send_request(prg_pkg::OP_RECT, 3, 5, 0, 0, 0);
    send_request(prg_pkg::OP_RECT, 36, 5, 0, 0, 0);
    send_request(prg_pkg::OP_RECT, 20, 21, 0, 0, 0);
    send_request(prg_pkg::OP_READ, 21, 0, 0, 0, 0);
  endtask

  task automatic test_rect_reject();
    set_columns(100);
    send_request(prg_pkg::OP_RECT, 99, 200, 0, 0, 0);
    send_request(prg_pkg::OP_RECT, 50, 210, 0, 0, 0);
    send_request(prg_pkg::OP_RECT, 0, 255, 0, 0, 0);
  endtask

  // Random mix: mostly writes and reads, with linear ramps, mostly short, and rectangles.
  task automatic test_random(int count);
    int a, kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      a = $urandom_range(255);
      if (kind < 4) send_random_write();
      else if (kind < 7) send_request(prg_pkg::OP_READ, a, $urandom_range(255), 0, 0, 0);
      else if (kind < 9)
        send_request(prg_pkg::OP_LINEAR, a, ($urandom_range(3) == 0) ? $urandom_range(255)
                     : (a + $urandom_range(24)) % 256, 0, 0, 0);
      else send_request(prg_pkg::OP_RECT, a, $urandom_range(255), 0, 0, 0);
    end
  endtask

  task automatic test_column_sweep();
    int unsigned widths [6] = '{1, 256, 0, 7, 511, 32};
    foreach (widths[k]) begin
      set_columns(widths[k]);
      test_random(50);
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
    grid_cols = 16;
    for (int i = 0; i < prg_pkg::ENTRIES; i++)
      for (int c = 0; c < prg_pkg::NUM_CH; c++) pal_model[i][c] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_rect_reject();
    set_columns(16);
    test_random(200);
    no_idle = 1'b1;
    test_random(60);
    no_idle = 1'b0;
    test_column_sweep();
    drain();
    $display("Sent %0d requests and checked %0d results across eight column counts.",
             sent, checked);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule
